/* hw/rtl/lsm_pkg.sv */
// Shared types and constants for the latency statistics monitor.
`default_nettype none

package lsm_pkg;

    localparam int LOG_DEPTH_DEFAULT = 32;
    localparam int ADDR_W            = 3;
    localparam int DATA_W            = 32;
    localparam int STAMP_W           = 64;
    localparam int COUNT_W           = 32;
    localparam int ENTRY_W           = 6;
    localparam int MUL_W             = 52;
    localparam int PROD_W            = 84;
    localparam int DIV_CNT_W         = $clog2(PROD_W);

    localparam logic [19:0]        US_PER_SEC     = 20'd1000000;
    localparam logic [DATA_W-1:0]  RES_RESET      = 32'd1000000;
    localparam logic [STAMP_W-1:0] POS_LIMIT      = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [STAMP_W-1:0] NEG_LIMIT      = 64'h8000_0000_0000_0000;

    // Register index, taken from paddr[2].
    localparam logic REG_LOG_EN    = 1'b0;
    localparam logic REG_TIMER_RES = 1'b1;

    typedef enum logic [1:0] {
        KIND_ENTRY = 2'd0,
        KIND_AVG   = 2'd1,
        KIND_MIN   = 2'd2,
        KIND_MAX   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SAMPLE,
        S_RPT,
        S_LOG_RD,
        S_LOG_VAL,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_SUM,
        S_CDIV,
        S_CDIV_WAIT,
        S_OUT,
        S_AVG_DIV,
        S_AVG_WAIT,
        S_AVG_VAL,
        S_MIN_VAL,
        S_MAX_VAL
    } state_t;

    typedef struct packed {
        logic  cap_dur;
        logic  upd_stats;
        logic  idx_clr;
        logic  idx_inc;
        logic  log_rd;
        logic  load_val;
        kind_t val_src;
        logic  mul_lo;
        logic  mul_hi;
        logic  mul_sum;
        logic  div_conv;
        logic  div_avg;
        logic  avg_cap;
        logic  sat_cap;
        logic  out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic  count_zero;
        logic  log_en;
        logic  idx_last;
        logic  div_done;
        logic  out_full;
        kind_t kind;
    } dp_status_t;

endpackage

`default_nettype wire

/* hw/rtl/latency_statistics_monitor.sv */
// Top level of the latency statistics monitor: config registers, controller and datapath.
//
// Usage: an input word (in_valid/in_ready) is either a sample (func = 0) carrying a
// start and end timestamp, or a report request (func = 1). A sample updates the
// running minimum, maximum, wrapping sum and saturating count and, with log_enable
// set, writes the duration into a LOG_DEPTH-entry ring log. It produces no output.
// A report with a nonzero count emits output words (out_valid/out_ready): the logged
// entries when logging is on, then average, minimum and maximum, each converted to
// microseconds as value * 1000000 / timer_resolution; last marks the maximum.
// A sample is handled in order: capture the difference, then update statistics; no new
// input is accepted until it is done. A report is dominated by the bit-serial divider,
// run once for each output word and once more for the average, and new input waits
// until the report is through.
// Configuration goes through the APB port: log_enable at 0x0, timer_resolution at
// 0x4; write only while the block is idle. pready is tied high.
// Reset clears the statistics to empty (minimum at the largest positive value,
// maximum at the most negative), marks all log slots as zero, sets log_enable to 0
// and timer_resolution to 1000000.
// Receiver stall: the output word holds until taken; the controller waits before
// loading the next word, and after the final word it is free to accept new input.
`default_nettype none

module latency_statistics_monitor
    import lsm_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    // APB configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,

    // Input channel
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               func,
    input  wire logic [STAMP_W-1:0] start_stamp,
    input  wire logic [STAMP_W-1:0] end_stamp,

    // Output channel
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [1:0]         kind,
    output logic      [ENTRY_W-1:0] entry_index,
    output logic signed [STAMP_W-1:0] micros,
    output logic                    last
);

    logic              log_en_reg;
    logic [DATA_W-1:0] timer_res_reg;
    logic              cfg_wr;
    logic [STAMP_W-1:0] micros_raw;
    dp_cmd_t           cmd;
    dp_status_t        status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // Register write on the APB access phase; the word index is paddr[2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_en_reg    <= 1'b0;
            timer_res_reg <= RES_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_LOG_EN:    log_en_reg    <= pwdata[0];
                REG_TIMER_RES: timer_res_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_LOG_EN:    prdata = {{(DATA_W-1){1'b0}}, log_en_reg};
            REG_TIMER_RES: prdata = timer_res_reg;
            default:       prdata = '0;
        endcase
    end

    // Sequence samples and report words
    lsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold statistics, log and conversion hardware
    lsm_datapath #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .log_enable       (log_en_reg),
        .timer_resolution (timer_res_reg),
        .start_stamp      (start_stamp),
        .end_stamp        (end_stamp),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .entry_index      (entry_index),
        .micros           (micros_raw),
        .last             (last)
    );

    assign micros = $signed(micros_raw);

endmodule

`default_nettype wire

/* hw/rtl/lsm_div.sv */
// Restoring divider, one quotient bit per cycle: 84-bit dividend, 32-bit divisor.
`default_nettype none

module lsm_div
    import lsm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic      [PROD_W-1:0] quot,
    output logic                   done
);

    logic [PROD_W-1:0]    q_reg, q_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DATA_W:0]      trial;
    logic [DATA_W:0]      diff;
    logic                 ge;

    always_comb
    begin
        trial    = {rem_reg, q_reg[PROD_W-1]};
        diff     = trial - {1'b0, d_reg};
        ge       = (trial >= {1'b0, d_reg});
        rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        q_next   = {q_reg[PROD_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(PROD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/lsm_datapath.sv */
// Datapath: statistics registers, duration log, microsecond conversion and output word.
`default_nettype none

module lsm_datapath
    import lsm_pkg::*;
#(
    parameter int LOG_DEPTH = LOG_DEPTH_DEFAULT
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    input  wire logic               log_enable,
    input  wire logic [DATA_W-1:0]  timer_resolution,
    input  wire logic [STAMP_W-1:0] start_stamp,
    input  wire logic [STAMP_W-1:0] end_stamp,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [1:0]         kind,
    output logic      [ENTRY_W-1:0] entry_index,
    output logic      [STAMP_W-1:0] micros,
    output logic                    last
);

    localparam int PTR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;

    // Running statistics
    logic [STAMP_W-1:0] dur_reg;
    logic [STAMP_W-1:0] min_reg;
    logic [STAMP_W-1:0] max_reg;
    logic [STAMP_W-1:0] sum_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [PTR_W-1:0]   ptr_reg;

    // Duration log
    logic [STAMP_W-1:0]   log_mem [LOG_DEPTH];
    logic [LOG_DEPTH-1:0] log_valid_reg;
    logic [STAMP_W-1:0]   rd_data_reg;
    logic                 rd_valid_reg;
    logic [PTR_W-1:0]     idx_reg;

    // Conversion
    logic [STAMP_W-1:0] avg_reg;
    logic               sum_neg_reg;
    logic [STAMP_W-1:0] mag_reg;
    logic               neg_reg;
    kind_t              kind_reg;
    logic [MUL_W-1:0]   plo_reg;
    logic [MUL_W-1:0]   phi_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [STAMP_W-1:0] sat_reg;

    // Output word
    logic               out_valid_reg;
    kind_t              out_kind_reg;
    logic [ENTRY_W-1:0] out_entry_reg;
    logic [STAMP_W-1:0] out_micros_reg;
    logic               out_last_reg;

    logic [STAMP_W-1:0] val_sel;
    logic [31:0]        mul_a;
    logic [MUL_W-1:0]   mul_p;
    logic [STAMP_W-1:0] sum_mag;
    logic [DATA_W-1:0]  res_eff;
    logic [PROD_W-1:0]  div_dividend;
    logic [DATA_W-1:0]  div_divisor;
    logic [PROD_W-1:0]  div_quot;
    logic               div_done;
    logic [STAMP_W-1:0] q64;
    logic [STAMP_W-1:0] limit;

    always_comb
    begin
        case (cmd.val_src)
            KIND_ENTRY: val_sel = rd_valid_reg ? rd_data_reg : '0;
            KIND_AVG:   val_sel = avg_reg;
            KIND_MIN:   val_sel = min_reg;
            KIND_MAX:   val_sel = max_reg;
            default:    val_sel = '0;
        endcase
    end

    // One 32x20 multiplier, shared by the low and high halves
    assign mul_a   = cmd.mul_hi ? mag_reg[63:32] : mag_reg[31:0];
    assign mul_p   = MUL_W'(mul_a) * MUL_W'(US_PER_SEC);

    assign sum_mag = sum_reg[STAMP_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign res_eff = (timer_resolution == '0) ? DATA_W'(1) : timer_resolution;

    assign div_dividend = cmd.div_conv ? prod_reg : PROD_W'(sum_mag);
    assign div_divisor  = cmd.div_conv ? res_eff : count_reg;

    lsm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_conv | cmd.div_avg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quot     (div_quot),
        .done     (div_done)
    );

    assign q64   = div_quot[STAMP_W-1:0];
    assign limit = neg_reg ? NEG_LIMIT : POS_LIMIT;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg       <= POS_LIMIT;
            max_reg       <= NEG_LIMIT;
            sum_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            log_valid_reg <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd_stats)
            begin
                if ($signed(dur_reg) < $signed(min_reg))
                    min_reg <= dur_reg;
                if ($signed(dur_reg) > $signed(max_reg))
                    max_reg <= dur_reg;
                sum_reg <= sum_reg + dur_reg;
                if (count_reg != '1)
                    count_reg <= count_reg + 1'b1;
                if (log_enable)
                begin
                    log_valid_reg[ptr_reg] <= 1'b1;
                    if (ptr_reg == PTR_W'(LOG_DEPTH - 1))
                        ptr_reg <= '0;
                    else
                        ptr_reg <= ptr_reg + 1'b1;
                end
            end

            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + 1'b1;

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Log storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.upd_stats && log_enable)
            log_mem[ptr_reg] <= dur_reg;
        if (cmd.log_rd)
        begin
            rd_data_reg  <= log_mem[idx_reg];
            rd_valid_reg <= log_valid_reg[idx_reg];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_dur)
            dur_reg <= end_stamp - start_stamp;
        if (cmd.load_val)
        begin
            neg_reg  <= val_sel[STAMP_W-1];
            mag_reg  <= val_sel[STAMP_W-1] ? (~val_sel + 1'b1) : val_sel;
            kind_reg <= cmd.val_src;
        end
        if (cmd.mul_lo)
            plo_reg <= mul_p;
        if (cmd.mul_hi)
            phi_reg <= mul_p;
        if (cmd.mul_sum)
            prod_reg <= PROD_W'(plo_reg) + {phi_reg, 32'b0};
        if (cmd.div_avg)
            sum_neg_reg <= sum_reg[STAMP_W-1];
        if (cmd.avg_cap)
            avg_reg <= sum_neg_reg ? (~q64 + 1'b1) : q64;
        if (cmd.sat_cap)
            sat_reg <= ((div_quot[PROD_W-1:STAMP_W] != '0) || (q64 > limit)) ? limit : q64;
        if (cmd.out_load)
        begin
            out_kind_reg   <= kind_reg;
            out_entry_reg  <= (kind_reg == KIND_ENTRY) ? ENTRY_W'(idx_reg) : '0;
            out_micros_reg <= neg_reg ? (~sat_reg + 1'b1) : sat_reg;
            out_last_reg   <= (kind_reg == KIND_MAX);
        end
    end

    always_comb
    begin
        status.count_zero = (count_reg == '0);
        status.log_en     = log_enable;
        status.idx_last   = (idx_reg == PTR_W'(LOG_DEPTH - 1))
                          || ((COUNT_W'(idx_reg) + COUNT_W'(1)) >= count_reg);
        status.div_done   = div_done;
        status.out_full   = out_valid_reg && !out_ready;
        status.kind       = kind_reg;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign entry_index = out_entry_reg;
    assign micros      = out_micros_reg;
    assign last        = out_last_reg;

endmodule

`default_nettype wire

/* hw/rtl/lsm_ctrl.sv */
// Controller state machine: sequences samples and report results.
`default_nettype none

module lsm_ctrl
    import lsm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       func,
    output logic            in_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.val_src = KIND_ENTRY;
        in_ready    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!func)
                    begin
                        cmd.cap_dur = 1'b1;
                        state_next  = S_SAMPLE;
                    end
                    else
                        state_next = S_RPT;
                end
            end
            S_SAMPLE:
            begin
                cmd.upd_stats = 1'b1;
                state_next    = S_IDLE;
            end
            S_RPT:
            begin
                if (status.count_zero)
                    state_next = S_IDLE;
                else
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = status.log_en ? S_LOG_RD : S_AVG_DIV;
                end
            end
            S_LOG_RD:
            begin
                cmd.log_rd = 1'b1;
                state_next = S_LOG_VAL;
            end
            S_LOG_VAL:
            begin
                cmd.load_val = 1'b1;
                cmd.val_src  = KIND_ENTRY;
                state_next   = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_MUL_SUM;
            end
            S_MUL_SUM:
            begin
                cmd.mul_sum = 1'b1;
                state_next  = S_CDIV;
            end
            S_CDIV:
            begin
                cmd.div_conv = 1'b1;
                state_next   = S_CDIV_WAIT;
            end
            S_CDIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.sat_cap = 1'b1;
                    state_next  = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    case (status.kind)
                        KIND_ENTRY:
                        begin
                            if (status.idx_last)
                                state_next = S_AVG_DIV;
                            else
                            begin
                                cmd.idx_inc = 1'b1;
                                state_next  = S_LOG_RD;
                            end
                        end
                        KIND_AVG: state_next = S_MIN_VAL;
                        KIND_MIN: state_next = S_MAX_VAL;
                        KIND_MAX: state_next = S_IDLE;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_AVG_DIV:
            begin
                cmd.div_avg = 1'b1;
                state_next  = S_AVG_WAIT;
            end
            S_AVG_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.avg_cap = 1'b1;
                    state_next  = S_AVG_VAL;
                end
            end
            S_AVG_VAL:
            begin
                cmd.load_val = 1'b1;
                cmd.val_src  = KIND_AVG;
                state_next   = S_MUL_LO;
            end
            S_MIN_VAL:
            begin
                cmd.load_val = 1'b1;
                cmd.val_src  = KIND_MIN;
                state_next   = S_MUL_LO;
            end
            S_MAX_VAL:
            begin
                cmd.load_val = 1'b1;
                cmd.val_src  = KIND_MAX;
                state_next   = S_MUL_LO;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the latency statistics monitor.
`timescale 1ns / 100ps

module tb_top;
    import lsm_pkg::*;

    localparam int LOG_SLOTS     = LOG_DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 100;   // lets a trailing sample finish, with margin
    localparam int DRAIN_CYCLES  = 300;   // covers one full result word plus the average divide
    localparam int QUIET_LIMIT   = 20000; // cycles with no handshake before giving up
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 52;

    // One expected result word of a report.
    typedef struct {
        kind_t              kind;
        logic [ENTRY_W-1:0] index;
        logic signed [63:0] micros;
        logic               last;
    } stat_word_t;

    // Tracks the monitor's statistics and the words each report must produce.
    class latency_stats_board;
        stat_word_t         pending_results[$];
        int unsigned        mismatches;
        int unsigned        words_checked;
        logic               log_on;
        logic [31:0]        ticks_per_sec;
        logic signed [63:0] dur_min;
        logic signed [63:0] dur_max;
        logic [63:0]        dur_total;
        logic [31:0]        sample_total;
        int unsigned        ring_wr;
        logic signed [63:0] ring [LOG_SLOTS];

        function new();
            mismatches    = 0;
            words_checked = 0;
            log_on        = 1'b0;
            ticks_per_sec = RES_RESET;
            dur_min       = POS_LIMIT;
            dur_max       = NEG_LIMIT;
            dur_total     = '0;
            sample_total  = '0;
            ring_wr       = 0;
            foreach (ring[i]) ring[i] = '0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void apply_register(logic idx, logic [31:0] value);
            if (idx == REG_LOG_EN)
                log_on = value[0];
            else
                ticks_per_sec = value;
        endfunction

        // value * 1e6 / resolution, exact, truncated toward zero, clamped to 64 bits
        function logic signed [63:0] scale_to_us(logic signed [63:0] v);
            logic [63:0]  mag;
            logic [127:0] divisor;
            logic [127:0] quot;
            logic [127:0] cap;
            mag     = v[63] ? (~v + 64'd1) : v;
            divisor = (ticks_per_sec == '0) ? 128'd1 : {96'd0, ticks_per_sec};
            quot    = ({64'd0, mag} * US_PER_SEC) / divisor;
            cap     = v[63] ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
            if (quot > cap)
                quot = cap;
            return v[63] ? -quot[63:0] : quot[63:0];
        endfunction

        function void queue_word(kind_t k, int slot, logic signed [63:0] v, logic fin);
            stat_word_t w;
            w.kind   = k;
            w.index  = slot[ENTRY_W-1:0];
            w.micros = scale_to_us(v);
            w.last   = fin;
            pending_results = {pending_results, w};
        endfunction

        // Update the statistics for an accepted word and queue what a report yields.
        function void note_word(logic is_report, logic [63:0] t0, logic [63:0] t1);
            logic signed [63:0] dur;
            logic signed [63:0] avg;
            int unsigned        shown;
            int                 slot;
            if (!is_report) begin
                dur = t1 - t0;
                if (dur < dur_min) dur_min = dur;
                if (dur > dur_max) dur_max = dur;
                dur_total += dur;
                if (sample_total != 32'hFFFF_FFFF)
                    sample_total++;
                if (log_on) begin
                    ring[ring_wr] = dur;
                    ring_wr = (ring_wr + 1) % LOG_SLOTS;
                end
                return;
            end
            // empty statistics: nothing comes back
            if (sample_total == '0)
                return;
            if (log_on) begin
                shown = (sample_total < LOG_SLOTS) ? sample_total : LOG_SLOTS;
                for (slot = 0; slot < shown; slot++)
                    queue_word(KIND_ENTRY, slot, ring[slot], 1'b0);
            end
            avg = $signed(dur_total) / $signed({32'd0, sample_total});
            queue_word(KIND_AVG, 0, avg, 1'b0);
            queue_word(KIND_MIN, 0, dur_min, 1'b0);
            queue_word(KIND_MAX, 0, dur_max, 1'b1);
        endfunction

        function void check_word(logic [1:0] k, logic [ENTRY_W-1:0] idx,
                                 logic signed [63:0] us, logic fin);
            stat_word_t want;
            words_checked++;
            if (pending_results.size() == 0) begin
                flag($sformatf("unexpected word kind %0d index %0d micros %0d last %0d",
                               k, idx, us, fin));
                return;
            end
            want = pending_results.pop_front();
            if (k !== want.kind || idx !== want.index || us !== want.micros
                    || fin !== want.last)
                flag($sformatf({"word %0d: expected kind %0d index %0d micros %0d last %0d,",
                                " got kind %0d index %0d micros %0d last %0d"},
                               words_checked, want.kind, want.index, want.micros,
                               want.last, k, idx, us, fin));
        endfunction
    endclass

    // Clock, reset and block I/O; every input starts at a known value.
    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               psel        = 1'b0;
    logic               penable     = 1'b0;
    logic               pwrite      = 1'b0;
    logic [ADDR_W-1:0]  paddr       = '0;
    logic [DATA_W-1:0]  pwdata      = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               func        = 1'b0;
    logic [STAMP_W-1:0] start_stamp = '0;
    logic [STAMP_W-1:0] end_stamp   = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [1:0]         kind;
    logic [ENTRY_W-1:0] entry_index;
    logic signed [STAMP_W-1:0] micros;
    logic               last;

    latency_stats_board board;
    bit                 steady      = 1'b0;  // suppress idling on both sides
    int                 quiet_cycles = 0;
    int unsigned        n_samples   = 0;
    int unsigned        n_reports   = 0;
    int unsigned        n_settings  = 0;

    latency_statistics_monitor u_top (.*);

    always #2 clk = ~clk;

    // Receive side: check each taken word, then stall at random unless steady.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_word(kind, entry_index, micros, last);
        out_ready <= steady || ($urandom_range(99) >= 7);
    end

    // Watchdog: any handshake or register access restarts the count.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL latency_statistics_monitor");
            $finish;
        end
    end

    // Offer one word and hold it until taken; idle first at random unless steady.
    task automatic push_item(logic is_report, logic [63:0] t0, logic [63:0] t1);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < 7) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= is_report;
        start_stamp <= t0;
        end_stamp   <= t1;
        do @(posedge clk); while (!in_ready);
        board.note_word(is_report, t0, t1);
        if (is_report) n_reports++;
        else n_samples++;
    endtask

    // Drop valid, wait for every expected word, then let a trailing sample finish.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write through setup and access cycles, then read the register back.
    task automatic reg_write(logic idx, logic [31:0] data);
        logic [31:0] want;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.apply_register(idx, data);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        want = (idx == REG_LOG_EN) ? {31'd0, data[0]} : data;
        if (prdata !== want)
            board.flag($sformatf("register %0d read back %0h, expected %0h",
                                 idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        logic [63:0] t0;
        logic [63:0] span;
        logic [31:0] res;
        int          phase;
        int          pick;
        bit          wide;

        board = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: report on empty statistics with reset registers.
        push_item(1'b1, 64'd0, 64'd0);
        settle();

        // Logging on at one tick per second, so each tick is a million microseconds.
        reg_write(REG_LOG_EN, 32'd1);
        reg_write(REG_TIMER_RES, 32'd1);
        n_settings++;
        push_item(1'b0, 64'd0, 64'd0);             // zero duration
        push_item(1'b0, 64'd0, '1);                // all-ones end, wraps to -1
        push_item(1'b0, '1, 64'd0);                // all-ones start, wraps to +1
        push_item(1'b0, NEG_LIMIT, POS_LIMIT);     // sign boundary on both stamps
        push_item(1'b0, 64'd5, 64'd3_000_005);
        push_item(1'b1, '1, '1);                   // stamps on a report are don't-care
        settle();

        // Zero resolution divides by one.
        reg_write(REG_TIMER_RES, 32'd0);
        n_settings++;
        push_item(1'b0, 64'd1000, 64'd1250);
        push_item(1'b1, 64'd0, 64'd0);
        settle();

        // Widest resolution with logging off: statistics only.
        reg_write(REG_LOG_EN, 32'd0);
        reg_write(REG_TIMER_RES, 32'hFFFF_FFFF);
        n_settings++;
        push_item(1'b0, 64'd1000, 64'd4_294_968_295);
        push_item(1'b1, 64'd0, 64'd0);
        settle();

        // Random phases: realistic short runs early, wide and extreme spans late.
        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            wide = (phase >= PHASES - 2);
            case ($urandom_range(5))
                0: res = 32'd1;
                1: res = 32'd1000;
                2: res = RES_RESET;
                3: res = 32'd1_000_000_000;
                4: res = 32'hFFFF_FFFF;
                default: res = $urandom;
            endcase
            if (phase == PHASES - 2)
                res = 32'd1;                       // force saturation of the conversion
            reg_write(REG_LOG_EN, {31'd0, phase % 3 != 2});
            reg_write(REG_TIMER_RES, res);
            n_settings++;
            steady = (phase == 3);
            repeat (PHASE_ITEMS) begin
                t0 = {$urandom, $urandom};
                if ($urandom_range(99) < 12) begin
                    push_item(1'b1, t0, {$urandom, $urandom});
                end
                else begin
                    pick = $urandom_range(wide ? 9 : 7);
                    case (pick)
                        6: span = {32'd0, $urandom};
                        7: span = -64'($urandom_range(1_000_000));
                        8: span = {$urandom, $urandom};
                        9: span = $urandom_range(1) ? POS_LIMIT : NEG_LIMIT;
                        default: span = 64'($urandom_range(20_000_000));
                    endcase
                    push_item(1'b0, t0, t0 + span);
                end
            end
        end
        steady = 1'b0;

        // Drain: wait for the last report, then give the block time to go quiet.
        in_valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d samples and %0d reports across %0d register settings",
                 n_samples, n_reports, n_settings);
        $display("checked %0d result words, %0d mismatches",
                 board.words_checked, board.mismatches);
        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("PASS latency_statistics_monitor");
        else
            $display("FAIL latency_statistics_monitor");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/lsm_pkg.sv
hw/rtl/lsm_div.sv
hw/rtl/lsm_datapath.sv
hw/rtl/lsm_ctrl.sv
hw/rtl/latency_statistics_monitor.sv
tb/tb_top.sv
